[rtl/rvx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared codes, types and helpers of the RV64IM execute unit.
// ----------------------------------------------------------------------------
package rvx_pkg;

  // operation codes
  localparam logic [5:0] F_ADD   = 6'd0;
  localparam logic [5:0] F_MUL   = 6'd1;
  localparam logic [5:0] F_SUB   = 6'd2;
  localparam logic [5:0] F_SLL   = 6'd3;
  localparam logic [5:0] F_MULH  = 6'd4;
  localparam logic [5:0] F_SLT   = 6'd5;
  localparam logic [5:0] F_XOR   = 6'd6;
  localparam logic [5:0] F_DIV   = 6'd7;
  localparam logic [5:0] F_SRL   = 6'd8;
  localparam logic [5:0] F_SRA   = 6'd9;
  localparam logic [5:0] F_OR    = 6'd10;
  localparam logic [5:0] F_REM   = 6'd11;
  localparam logic [5:0] F_AND   = 6'd12;
  localparam logic [5:0] F_ADDW  = 6'd13;
  localparam logic [5:0] F_SUBW  = 6'd14;
  localparam logic [5:0] F_MULW  = 6'd15;
  localparam logic [5:0] F_DIVW  = 6'd16;
  localparam logic [5:0] F_REMW  = 6'd17;
  localparam logic [5:0] F_SLLW  = 6'd18;
  localparam logic [5:0] F_SRLW  = 6'd19;
  localparam logic [5:0] F_SRAW  = 6'd20;
  localparam logic [5:0] F_ADDI  = 6'd21;
  localparam logic [5:0] F_SLLI  = 6'd22;
  localparam logic [5:0] F_SLTI  = 6'd23;
  localparam logic [5:0] F_XORI  = 6'd24;
  localparam logic [5:0] F_SRLI  = 6'd25;
  localparam logic [5:0] F_SRAI  = 6'd26;
  localparam logic [5:0] F_ORI   = 6'd27;
  localparam logic [5:0] F_ANDI  = 6'd28;
  localparam logic [5:0] F_ADDIW = 6'd29;
  localparam logic [5:0] F_JALR  = 6'd30;
  localparam logic [5:0] F_ECALL = 6'd31;
  localparam logic [5:0] F_BEQ   = 6'd32;
  localparam logic [5:0] F_BNE   = 6'd33;
  localparam logic [5:0] F_BLT   = 6'd34;
  localparam logic [5:0] F_BGE   = 6'd35;
  localparam logic [5:0] F_BLTU  = 6'd36;
  localparam logic [5:0] F_BGEU  = 6'd37;
  localparam logic [5:0] F_AUIPC = 6'd38;
  localparam logic [5:0] F_LUI   = 6'd39;
  localparam logic [5:0] F_JAL   = 6'd40;

  localparam int unsigned XLEN      = 64;
  localparam int unsigned DIV_STEPS = 64;
  localparam logic [63:0] STEP_BYTES = 64'd4;

  // which unit produces the final result
  typedef enum logic [2:0] {
    K_ALU, K_MUL, K_MULH, K_MULW, K_DIV, K_REM, K_DIVW, K_REMW
  } kind_e;

  // data that travels beside the divider datapath
  typedef struct packed {
    logic [63:0] res;
    logic        take;
    logic [63:0] npc;
    kind_e       kind;
    logic        neg_q;
    logic        neg_r;
    logic        div0;
  } side_t;

  function automatic logic [63:0] sext32(input logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

endpackage

[rtl/rvx_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_if
// Request and response channels of the RV64IM execute unit.
// ----------------------------------------------------------------------------
interface rvx_req_if;
  logic        valid;
  logic        ready;
  logic [5:0]  func;
  logic [63:0] operand_a;
  logic [63:0] operand_b;
  logic [31:0] imm;
  logic [63:0] pc;

  modport source (output valid, func, operand_a, operand_b, imm, pc, input ready);
  modport sink   (input valid, func, operand_a, operand_b, imm, pc, output ready);
endinterface

interface rvx_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result;
  logic        take_branch;
  logic [63:0] next_pc;

  modport source (output valid, result, take_branch, next_pc, input ready);
  modport sink   (input valid, result, take_branch, next_pc, output ready);
endinterface

[rtl/rv64im_execute_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv64im_execute_unit
// Pipelined RV64IM execute stage: ALU, branch, multiply and divide.
// ----------------------------------------------------------------------------
// channel  dir  fields
// req_i    in   func, operand_a, operand_b, imm, pc
// rsp_o    out  result, take_branch, next_pc
//
// one item enters per cycle while the output register is not stalled; every
// item passes 67 register stages (decode/products, product sum, 64 divider
// bit stages, output), and the output register holds its result
// the divider takes one quotient bit per stage
// all stages move together; a stalled output register freezes the pipe
// reset clears the valid bits only
// ----------------------------------------------------------------------------
module rv64im_execute_unit (
  input  logic clk_i,
  input  logic rst_ni,
  rvx_req_if.sink   req_i,
  rvx_rsp_if.source rsp_o
);

  logic en;
  logic out_vld_q;

  assign en          = !out_vld_q || rsp_o.ready;
  assign req_i.ready = en;

  // stage 1 decode
  logic [63:0] a, b, imm64, seq, sum_ai, pc_imm;
  logic [63:0] res_d, npc_d, ua_d, ub_d;
  logic        take_d, na, nb;
  rvx_pkg::kind_e kind_d;
  logic [31:0] aw_abs, bw_abs;

  assign a      = req_i.operand_a;
  assign b      = req_i.operand_b;
  assign imm64  = rvx_pkg::sext32(req_i.imm);
  assign seq    = req_i.pc + rvx_pkg::STEP_BYTES;
  assign sum_ai = a + imm64;
  assign pc_imm = req_i.pc + imm64;

  always_comb begin
    res_d  = '0;
    take_d = 1'b0;
    npc_d  = seq;
    kind_d = rvx_pkg::K_ALU;
    unique case (req_i.func)
      rvx_pkg::F_ADD:   res_d = a + b;
      rvx_pkg::F_MUL:   kind_d = rvx_pkg::K_MUL;
      rvx_pkg::F_SUB:   res_d = a - b;
      rvx_pkg::F_SLL:   res_d = a << b[5:0];
      rvx_pkg::F_MULH:  kind_d = rvx_pkg::K_MULH;
      rvx_pkg::F_SLT:   res_d = {63'b0, $signed(a) < $signed(b)};
      rvx_pkg::F_XOR:   res_d = a ^ b;
      rvx_pkg::F_DIV:   kind_d = rvx_pkg::K_DIV;
      rvx_pkg::F_SRL:   res_d = a >> b[5:0];
      rvx_pkg::F_SRA:   res_d = $unsigned($signed(a) >>> b[5:0]);
      rvx_pkg::F_OR:    res_d = a | b;
      rvx_pkg::F_REM:   kind_d = rvx_pkg::K_REM;
      rvx_pkg::F_AND:   res_d = a & b;
      rvx_pkg::F_ADDW:  res_d = rvx_pkg::sext32(a[31:0] + b[31:0]);
      rvx_pkg::F_SUBW:  res_d = rvx_pkg::sext32(a[31:0] - b[31:0]);
      rvx_pkg::F_MULW:  kind_d = rvx_pkg::K_MULW;
      rvx_pkg::F_DIVW:  kind_d = rvx_pkg::K_DIVW;
      rvx_pkg::F_REMW:  kind_d = rvx_pkg::K_REMW;
      rvx_pkg::F_SLLW:  res_d = rvx_pkg::sext32(a[31:0] << b[4:0]);
      rvx_pkg::F_SRLW:  res_d = rvx_pkg::sext32(a[31:0] >> b[4:0]);
      rvx_pkg::F_SRAW:  res_d = rvx_pkg::sext32($unsigned($signed(a[31:0]) >>> b[4:0]));
      rvx_pkg::F_ADDI:  res_d = sum_ai;
      rvx_pkg::F_SLLI:  res_d = a << imm64[5:0];
      rvx_pkg::F_SLTI:  res_d = {63'b0, $signed(a) < $signed(imm64)};
      rvx_pkg::F_XORI:  res_d = a ^ imm64;
      rvx_pkg::F_SRLI:  res_d = a >> imm64[5:0];
      rvx_pkg::F_SRAI:  res_d = $unsigned($signed(a) >>> imm64[5:0]);
      rvx_pkg::F_ORI:   res_d = a | imm64;
      rvx_pkg::F_ANDI:  res_d = a & imm64;
      rvx_pkg::F_ADDIW: res_d = rvx_pkg::sext32(sum_ai[31:0]);
      rvx_pkg::F_JALR: begin
        res_d = sum_ai;
        npc_d = {sum_ai[63:1], 1'b0};
      end
      rvx_pkg::F_ECALL: res_d = '0;
      rvx_pkg::F_BEQ:   take_d = (a == b);
      rvx_pkg::F_BNE:   take_d = (a != b);
      rvx_pkg::F_BLT:   take_d = $signed(a) < $signed(b);
      rvx_pkg::F_BGE:   take_d = !($signed(a) < $signed(b));
      rvx_pkg::F_BLTU:  take_d = (a < b);
      rvx_pkg::F_BGEU:  take_d = (a >= b);
      rvx_pkg::F_AUIPC: res_d = pc_imm;
      rvx_pkg::F_LUI:   res_d = imm64;
      rvx_pkg::F_JAL: begin
        res_d = pc_imm;
        npc_d = pc_imm;
      end
      default: res_d = '0;
    endcase
    // conditional branches report the target
    if (req_i.func >= rvx_pkg::F_BEQ && req_i.func <= rvx_pkg::F_BGEU) begin
      res_d = pc_imm;
      npc_d = take_d ? pc_imm : seq;
    end
  end

  // divider operand magnitudes
  logic wform;
  assign wform  = (kind_d == rvx_pkg::K_DIVW) || (kind_d == rvx_pkg::K_REMW);
  assign na     = wform ? a[31] : a[63];
  assign nb     = wform ? b[31] : b[63];
  assign aw_abs = a[31] ? (32'd0 - a[31:0]) : a[31:0];
  assign bw_abs = b[31] ? (32'd0 - b[31:0]) : b[31:0];
  assign ua_d   = wform ? {32'b0, aw_abs} : (a[63] ? (64'd0 - a) : a);
  assign ub_d   = wform ? {32'b0, bw_abs} : (b[63] ? (64'd0 - b) : b);

  logic           s1_vld_q;
  rvx_pkg::side_t s1_side_q;
  logic [63:0]    s1_p0_q, s1_p1_q, s1_p2_q, s1_p3_q, s1_a_q, s1_b_q, s1_ua_q, s1_ub_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_side_q <= '{res: res_d, take: take_d, npc: npc_d, kind: kind_d,
                     neg_q: na ^ nb, neg_r: na,
                     div0: wform ? (b[31:0] == 32'd0) : (b == 64'd0)};
      s1_p0_q <= a[31:0]  * b[31:0];
      s1_p1_q <= a[31:0]  * b[63:32];
      s1_p2_q <= a[63:32] * b[31:0];
      s1_p3_q <= a[63:32] * b[63:32];
      s1_a_q  <= a;
      s1_b_q  <= b;
      s1_ua_q <= ua_d;
      s1_ub_q <= ub_d;
    end
  end

  // stage 2 product sum
  logic [63:0]    mid, hi, lo;
  rvx_pkg::side_t s2_side_d;

  assign mid = {32'b0, s1_p0_q[63:32]} + {32'b0, s1_p1_q[31:0]} + {32'b0, s1_p2_q[31:0]};
  assign lo  = {mid[31:0], s1_p0_q[31:0]};
  assign hi  = s1_p3_q + {32'b0, s1_p1_q[63:32]} + {32'b0, s1_p2_q[63:32]}
             + {32'b0, mid[63:32]}
             - (s1_a_q[63] ? s1_b_q : 64'd0) - (s1_b_q[63] ? s1_a_q : 64'd0);

  always_comb begin
    s2_side_d = s1_side_q;
    case (s1_side_q.kind)
      rvx_pkg::K_MUL:  s2_side_d.res = lo;
      rvx_pkg::K_MULH: s2_side_d.res = hi;
      rvx_pkg::K_MULW: s2_side_d.res = rvx_pkg::sext32(s1_p0_q[31:0]);
      default:         s2_side_d.res = s1_side_q.res;
    endcase
  end

  logic           s2_vld_q;
  rvx_pkg::side_t s2_side_q;
  logic [63:0]    s2_ua_q, s2_ub_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_side_q <= s2_side_d;
      s2_ua_q   <= s1_ua_q;
      s2_ub_q   <= s1_ub_q;
    end
  end

  // divider stages
  logic           dv_vld;
  rvx_pkg::side_t dv_side;
  logic [63:0]    dv_quo, dv_rem;

  rvx_div_pipe u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s2_vld_q),
    .side_i (s2_side_q),
    .ua_i   (s2_ua_q),
    .ub_i   (s2_ub_q),
    .vld_o  (dv_vld),
    .side_o (dv_side),
    .quo_o  (dv_quo),
    .rem_o  (dv_rem)
  );

  // sign fixup and result select
  logic [63:0] fin_d;

  always_comb begin
    case (dv_side.kind)
      rvx_pkg::K_DIV:  fin_d = dv_side.div0 ? '1
                             : (dv_side.neg_q ? (64'd0 - dv_quo) : dv_quo);
      rvx_pkg::K_REM:  fin_d = dv_side.neg_r ? (64'd0 - dv_rem) : dv_rem;
      rvx_pkg::K_DIVW: fin_d = dv_side.div0 ? '1 : rvx_pkg::sext32(
                             dv_side.neg_q ? (32'd0 - dv_quo[31:0]) : dv_quo[31:0]);
      rvx_pkg::K_REMW: fin_d = rvx_pkg::sext32(
                             dv_side.neg_r ? (32'd0 - dv_rem[31:0]) : dv_rem[31:0]);
      default:         fin_d = dv_side.res;
    endcase
  end

  // output register
  logic [63:0] out_res_q, out_npc_q;
  logic        out_take_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_res_q  <= fin_d;
      out_take_q <= dv_side.take;
      out_npc_q  <= dv_side.npc;
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.result      = out_res_q;
  assign rsp_o.take_branch = out_take_q;
  assign rsp_o.next_pc     = out_npc_q;

  // a blocked output freezes the input side
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !rsp_o.ready |-> !req_i.ready)
    else $error("input accepted while output stalled");

  // an accepted item reaches stage 1
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> s1_vld_q)
    else $error("accepted item lost at stage 1");

  // a frozen pipe keeps its stage valid bits
  a_freeze_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(s1_vld_q) && $stable(s2_vld_q) && $stable(dv_vld))
    else $error("stage valid changed during stall");

  // only branch items set the taken flag, and they pass through the alu path
  a_take_alu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q && s2_side_q.take |-> s2_side_q.kind == rvx_pkg::K_ALU)
    else $error("taken flag on a non-alu item");

endmodule

[rtl/rvx_div_pipe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_div_pipe
// Unsigned restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rvx_div_pipe (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  rvx_pkg::side_t side_i,
  input  logic [63:0]    ua_i,
  input  logic [63:0]    ub_i,
  output logic           vld_o,
  output rvx_pkg::side_t side_o,
  output logic [63:0]    quo_o,
  output logic [63:0]    rem_o
);

  logic           vld_q  [rvx_pkg::DIV_STEPS];
  rvx_pkg::side_t side_q [rvx_pkg::DIV_STEPS];
  logic [63:0]    rem_q  [rvx_pkg::DIV_STEPS];
  logic [63:0]    qd_q   [rvx_pkg::DIV_STEPS];
  logic [63:0]    ub_q   [rvx_pkg::DIV_STEPS];

  for (genvar g = 0; g < rvx_pkg::DIV_STEPS; g++) begin : g_step
    logic           vld_in;
    rvx_pkg::side_t side_in;
    logic [63:0]    rem_in, qd_in, ub_in;
    logic [64:0]    rs, diff;
    logic           ge;

    if (g == 0) begin : g_first
      assign vld_in  = vld_i;
      assign side_in = side_i;
      assign rem_in  = '0;
      assign qd_in   = ua_i;
      assign ub_in   = ub_i;
    end else begin : g_next
      assign vld_in  = vld_q[g-1];
      assign side_in = side_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign qd_in   = qd_q[g-1];
      assign ub_in   = ub_q[g-1];
    end

    // shift in next dividend bit, subtract when it fits
    assign rs   = {rem_in, qd_in[63]};
    assign diff = rs - {1'b0, ub_in};
    assign ge   = (rs >= {1'b0, ub_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[g] <= side_in;
        rem_q[g]  <= ge ? diff[63:0] : rs[63:0];
        qd_q[g]   <= {qd_in[62:0], ge};
        ub_q[g]   <= ub_in;
      end
    end
  end

  assign vld_o  = vld_q[rvx_pkg::DIV_STEPS-1];
  assign side_o = side_q[rvx_pkg::DIV_STEPS-1];
  assign quo_o  = qd_q[rvx_pkg::DIV_STEPS-1];
  assign rem_o  = rem_q[rvx_pkg::DIV_STEPS-1];

endmodule
